>>> rtl/dls_pkg.sv
// Shared types, constants and palette function for the disk label stamper.
package dls_pkg;

	// Default frame size
	localparam int unsigned DLS_IMAGE_WIDTH  = 256;
	localparam int unsigned DLS_IMAGE_HEIGHT = 256;

	// Field widths
	localparam int unsigned POS_W    = 12;
	localparam int unsigned GROUP_W  = 8;
	localparam int unsigned LABEL_W  = 8;
	localparam int unsigned COLOUR_W = 8;
	localparam int unsigned RADIUS_W = 4;
	localparam int unsigned SCALE_W  = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// Scaled centre width and disk offset width (signed, covers -15..15)
	localparam int unsigned CENTRE_W = POS_W + SCALE_W;
	localparam int unsigned OFF_W    = RADIUS_W + 1;

	// Opcodes
	localparam logic OP_STAMP = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE     = 2'd2;

	// Configuration reset values
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd5;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 9'd1;

	// Palette
	localparam logic [LABEL_W-1:0]  LABEL_RED  = 8'd1;
	localparam logic [LABEL_W-1:0]  LABEL_BLUE = 8'd2;
	localparam logic [COLOUR_W-1:0] COLOUR_MAX = 8'd255;
	localparam logic [COLOUR_W-1:0] COLOUR_MIN = 8'd0;

	typedef struct packed {
		logic               opcode;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [GROUP_W-1:0] group_number;
		logic               last_in_batch;
	} dls_item_t;

	typedef struct packed {
		logic [LABEL_W-1:0]  pixel_label;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} dls_result_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic scale;
		logic scan_step;
		logic rd_issue;
	} dls_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
	} dls_status_t;

	// Label to colour lookup
	function automatic dls_result_t dls_palette(input logic [LABEL_W-1:0] label);
		dls_result_t res;
		res.pixel_label = label;
		unique case (label)
			LABEL_RED: begin
				res.red   = COLOUR_MAX;
				res.green = COLOUR_MIN;
				res.blue  = COLOUR_MIN;
			end
			LABEL_BLUE: begin
				res.red   = COLOUR_MIN;
				res.green = COLOUR_MIN;
				res.blue  = COLOUR_MAX;
			end
			default: begin
				res.red   = COLOUR_MAX;
				res.green = COLOUR_MAX;
				res.blue  = COLOUR_MAX;
			end
		endcase
		return res;
	endfunction

endpackage

>>> rtl/dls_ctrl.sv
// Controller state machine: clearing pass, stamp scan sequencing and pixel reads.
module dls_ctrl import dls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        opcode,
	output logic        busy,
	output logic        done,
	output dls_cmd_t    cmd,
	input  dls_status_t status
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_SCAN,
		ST_READ,
		ST_RESP
	} state_t;

	state_t state_q;

	// Command decode
	always_comb begin
		cmd.clr_step  = (state_q == ST_CLEAR);
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.scale     = (state_q == ST_SCALE);
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.rd_issue  = (state_q == ST_READ);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (opcode == OP_READ) state_q <= ST_READ;
						else                   state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (status.scan_last) state_q <= ST_IDLE;
				end
				ST_READ: state_q <= ST_RESP;
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.load, cmd.scale, cmd.scan_step, cmd.rd_issue}))
		else $error("dls_ctrl: more than one datapath command at once");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && status.scan_last) |=> !busy)
		else $error("dls_ctrl: still busy after last scan step");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("dls_ctrl: result strobe longer than one cycle");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_READ) |-> ##2 done)
		else $error("dls_ctrl: read result not delivered two cycles after accept");

endmodule

>>> rtl/dls_datapath.sv
// Datapath: configuration registers, centre scaling, disk scan and label frame memory.
module dls_datapath import dls_pkg::*; #(
	parameter int unsigned IMAGE_WIDTH  = DLS_IMAGE_WIDTH,
	parameter int unsigned IMAGE_HEIGHT = DLS_IMAGE_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dls_item_t             item,
	input  dls_cmd_t              cmd,
	output dls_status_t           status,
	output dls_result_t           result
);

	localparam int unsigned XW    = $clog2(IMAGE_WIDTH);
	localparam int unsigned YW    = $clog2(IMAGE_HEIGHT);
	localparam int unsigned DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned TW    = CENTRE_W + 2;

	// Configuration registers
	logic [RADIUS_W-1:0] radius_q;
	logic [SCALE_W-1:0]  x_scale_q;
	logic [SCALE_W-1:0]  y_scale_q;

	// Latched transaction
	logic [POS_W-1:0]   pos_x_q;
	logic [POS_W-1:0]   pos_y_q;
	logic [LABEL_W-1:0] label_q;

	// Scan state
	logic [CENTRE_W-1:0] cx_q;
	logic [CENTRE_W-1:0] cy_q;
	logic [OFF_W-1:0]    dx_q;
	logic [OFF_W-1:0]    dy_q;
	logic [AW-1:0]       clr_cnt_q;

	// Write stage
	logic          we_s1;
	logic [XW-1:0] tx_s1;
	logic [YW-1:0] ty_s1;

	// Read side
	logic               in_frame_q;
	logic [LABEL_W-1:0] rd_q;

	logic [LABEL_W-1:0] label_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RESET;
			x_scale_q <= SCALE_RESET;
			y_scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DISK_RADIUS: radius_q  <= cfg_data[RADIUS_W-1:0];
				CFG_X_SCALE:     x_scale_q <= cfg_data;
				CFG_Y_SCALE:     y_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the accepted transaction; label wraps in 8 bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q <= item.pos_x;
			pos_y_q <= item.pos_y;
			label_q <= item.group_number + LABEL_W'(1);
		end
	end

	// Centre pixel from world position
	logic [CENTRE_W-1:0] cx_prod;
	logic [CENTRE_W-1:0] cy_prod;
	assign cx_prod = CENTRE_W'(x_scale_q) * CENTRE_W'(pos_x_q);
	assign cy_prod = CENTRE_W'(y_scale_q) * CENTRE_W'(pos_y_q);

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			cx_q <= cx_prod;
			cy_q <= cy_prod;
		end
	end

	// Offset counters walk the square row by row
	logic [OFF_W-1:0] r_ext;
	logic [OFF_W-1:0] neg_r;
	logic             dx_end;
	assign r_ext  = {1'b0, radius_q};
	assign neg_r  = OFF_W'(0) - r_ext;
	assign dx_end = (dx_q == r_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0;
			dy_q <= '0;
		end else if (cmd.scale) begin
			dx_q <= neg_r;
			dy_q <= neg_r;
		end else if (cmd.scan_step) begin
			if (dx_end) begin
				dx_q <= neg_r;
				dy_q <= dy_q + OFF_W'(1);
			end else begin
				dx_q <= dx_q + OFF_W'(1);
			end
		end
	end

	assign status.scan_last = dx_end && (dy_q == r_ext);

	// Disk membership: dx^2 + dy^2 <= r^2
	logic [OFF_W-1:0]      ndx;
	logic [OFF_W-1:0]      ndy;
	logic [RADIUS_W-1:0]   adx;
	logic [RADIUS_W-1:0]   ady;
	logic [2*RADIUS_W-1:0] sq_x;
	logic [2*RADIUS_W-1:0] sq_y;
	logic [2*RADIUS_W-1:0] r_sq;
	logic [2*RADIUS_W:0]   dsq;
	logic                  in_disk;

	assign ndx     = OFF_W'(0) - dx_q;
	assign ndy     = OFF_W'(0) - dy_q;
	assign adx     = dx_q[OFF_W-1] ? ndx[RADIUS_W-1:0] : dx_q[RADIUS_W-1:0];
	assign ady     = dy_q[OFF_W-1] ? ndy[RADIUS_W-1:0] : dy_q[RADIUS_W-1:0];
	assign sq_x    = (2*RADIUS_W)'(adx) * (2*RADIUS_W)'(adx);
	assign sq_y    = (2*RADIUS_W)'(ady) * (2*RADIUS_W)'(ady);
	assign r_sq    = (2*RADIUS_W)'(radius_q) * (2*RADIUS_W)'(radius_q);
	assign dsq     = {1'b0, sq_x} + {1'b0, sq_y};
	assign in_disk = (dsq <= {1'b0, r_sq});

	// Target pixel and frame clipping
	logic [TW-1:0] tx;
	logic [TW-1:0] ty;
	logic          in_x;
	logic          in_y;

	assign tx   = {2'b00, cx_q} + {{(TW-OFF_W){dx_q[OFF_W-1]}}, dx_q};
	assign ty   = {2'b00, cy_q} + {{(TW-OFF_W){dy_q[OFF_W-1]}}, dy_q};
	assign in_x = !tx[TW-1] && (tx[TW-2:0] < (TW-1)'(IMAGE_WIDTH));
	assign in_y = !ty[TW-1] && (ty[TW-2:0] < (TW-1)'(IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= cmd.scan_step && in_disk && in_x && in_y;
		end
	end

	always_ff @(posedge clk) begin
		tx_s1 <= tx[XW-1:0];
		ty_s1 <= ty[YW-1:0];
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign status.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	// Memory addressing
	logic [AW-1:0]      stamp_addr;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [LABEL_W-1:0] wr_data;
	logic               mem_we;
	logic               mem_re;
	logic               rd_in_frame;

	assign stamp_addr  = AW'(ty_s1) * AW'(IMAGE_WIDTH) + AW'(tx_s1);
	assign rd_addr     = AW'(pos_y_q[YW-1:0]) * AW'(IMAGE_WIDTH) + AW'(pos_x_q[XW-1:0]);
	assign rd_in_frame = ({1'b0, pos_x_q} < (POS_W+1)'(IMAGE_WIDTH))
	                  && ({1'b0, pos_y_q} < (POS_W+1)'(IMAGE_HEIGHT));
	assign mem_we      = cmd.clr_step || we_s1;
	assign wr_addr     = cmd.clr_step ? clr_cnt_q : stamp_addr;
	assign wr_data     = cmd.clr_step ? '0 : label_q;
	assign mem_re      = cmd.rd_issue && rd_in_frame;

	// Label frame
	always_ff @(posedge clk) begin
		if (mem_we) label_mem[wr_addr] <= wr_data;
		if (mem_re) rd_q <= label_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (cmd.rd_issue) begin
			in_frame_q <= rd_in_frame;
		end
	end

	// Result with palette colour; outside the frame reads as empty
	assign result = dls_palette(in_frame_q ? rd_q : LABEL_W'(0));

endmodule

>>> rtl/disk_label_stamper_unit.sv
// Top level of the disk label stamper: controller, datapath and port wiring.
//
// Label frame of IMAGE_WIDTH x IMAGE_HEIGHT 8-bit labels, one memory write port and
// one registered read port. After reset the block runs a clearing pass over all
// IMAGE_WIDTH*IMAGE_HEIGHT labels (65536 at the default size) with busy high; the
// configuration channel is always ready, also during that pass. A stamp transaction
// first scales the centre in the scale state, then scans one offset of the square per
// cycle through the single memory write port. A read transaction issues the
// registered read and then presents its result with done for exactly one cycle in
// the response state that follows; the receiver cannot stall, so the result must
// be taken in that cycle. Stamps give no result.
module disk_label_stamper_unit import dls_pkg::*; #(
	parameter int unsigned IMAGE_WIDTH  = DLS_IMAGE_WIDTH,
	parameter int unsigned IMAGE_HEIGHT = DLS_IMAGE_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dls_item_t             item,
	output logic                  done,
	output dls_result_t           result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dls_cmd_t    cmd;
	dls_status_t status;

	assign cfg_ready = 1'b1;

	dls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	dls_datapath #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule
